// File: rtl/pwnl_pkg.sv
package pwnl_pkg;

    // Store and field sizes
    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int NODE_W     = 10;
    localparam int DIST_W     = 36;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int RAM_W      = 3 * COORD_BITS;

    // Squared-distance arithmetic
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = SQ_W + 2;
    localparam int WIDE_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((NODE_W + DIST_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1 + STATUS_W;

    // Opcodes (code three behaves as locate)
    localparam logic [OP_W-1:0] OP_FIND_OR_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD         = 2'd1;
    localparam logic [OP_W-1:0] OP_LOCATE      = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;    // latch input transaction, restart scan
        logic rd_en;   // read next stored point
        logic finish;  // decide, append, load result
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;  // every stored point has been read
        logic pipe_busy;  // distance pipeline still holds a point
        logic out_free;   // result register can take a new result
    } t_ctl_sts;

    // Squared magnitude of a - b
    function automatic logic [SQ_W-1:0] sq_abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        logic        [COORD_BITS:0] m;
        d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        m = d[COORD_BITS] ? (COORD_BITS+1)'(-d) : d;
        return SQ_W'(m[COORD_BITS-1:0]) * SQ_W'(m[COORD_BITS-1:0]);
    endfunction

    // Clamp a distance sum to the result field
    function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] d);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(d);
        if (w > WIDE_W'({DIST_W{1'b1}})) begin
            return {DIST_W{1'b1}};
        end
        return w[DIST_W-1:0];
    endfunction

endpackage

// File: rtl/pwnl_ram.sv
module pwnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/pwnl_ctrl.sv
module pwnl_ctrl
    import pwnl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan only starts from an accepted transaction
    a_scan_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && $past(r_state == S_IDLE) |-> $past(o_cmd.load))
        else $error("scan entered without a load");

    // Finish is only reached with an empty pipeline
    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> !i_sts.pipe_busy)
        else $error("finish with points still in flight");

    // No input taken while a transaction is in progress
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");

endmodule

// File: rtl/pwnl_datapath.sv
module pwnl_datapath
    import pwnl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input transaction payload
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [COORD_BITS-1:0] i_px,
    input  logic [COORD_BITS-1:0] i_py,
    input  logic [COORD_BITS-1:0] i_pz,
    // Tolerance register write
    input  logic                  i_cfg_we,
    input  logic [DIST_W-1:0]     i_cfg_data,
    // Controller link
    input  t_ctl_cmd              i_cmd,
    output t_ctl_sts              o_sts,
    // Result
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [NODE_W-1:0]     o_node_index,
    output logic                  o_reused,
    output logic [STATUS_W-1:0]   o_status,
    output logic [DIST_W-1:0]     o_dist
);

    // Latched transaction and tolerance
    logic [OP_W-1:0]       r_op;
    logic [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic [DIST_W-1:0]     r_tol;

    // Store fill and scan address
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_addr;

    // Distance pipeline
    logic                  r_v1, r_v2;
    logic [IDX_W-1:0]      r_idx1, r_idx2;
    logic [SQ_W-1:0]       r_sq_x, r_sq_y, r_sq_z;
    logic [SUM_W-1:0]      w_sum;

    // Running minimum
    logic [IDX_W-1:0]      r_best;
    logic [SUM_W-1:0]      r_best_d;

    // Result register
    logic                  r_out_valid;
    logic [NODE_W-1:0]     r_node_index;
    logic                  r_reused;
    logic [STATUS_W-1:0]   r_status;
    logic [DIST_W-1:0]     r_dist;

    // Finish decision
    logic                  w_empty, w_full, w_append, w_wr_en;
    logic [IDX_W-1:0]      n_node;
    logic                  n_reused;
    logic [STATUS_W-1:0]   n_status;

    logic [RAM_W-1:0]      w_rd_data;

    pwnl_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data ({r_pz, r_py, r_px}),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_addr[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_sum = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);

    // Decide reuse, append or locate once the scan is over
    always_comb begin
        w_empty  = (r_count == '0);
        w_full   = (r_count == CNT_W'(MAX_POINTS));
        w_append = 1'b0;
        n_node   = '0;
        n_reused = 1'b0;
        n_status = ST_OK;
        case (r_op)
            OP_FIND_OR_ADD: begin
                if (!w_empty && (WIDE_W'(r_best_d) < WIDE_W'(r_tol))) begin
                    n_node   = r_best;
                    n_reused = 1'b1;
                end else begin
                    w_append = 1'b1;
                end
            end
            OP_ADD: begin
                w_append = 1'b1;
            end
            default: begin
                // locate, also taken by code three
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_node   = r_best;
                    n_reused = 1'b1;
                end
            end
        endcase
        if (w_append) begin
            if (w_full) begin
                n_node   = r_best;
                n_status = ST_FULL;
            end else begin
                n_node = r_count[IDX_W-1:0];
            end
        end
        w_wr_en = i_cmd.finish && w_append && !w_full;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= '0;
            r_count     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if (w_wr_en) begin
                r_count <= r_count + 1'b1;
            end
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // transaction latch and scan address
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_px     <= i_px;
            r_py     <= i_py;
            r_pz     <= i_pz;
            r_addr   <= '0;
            r_best   <= '0;
            r_best_d <= '0;
        end else begin
            if (i_cmd.rd_en) begin
                r_addr <= r_addr + 1'b1;
            end
            // running minimum, first point always taken, ties keep lower index
            if (r_v2 && ((r_idx2 == '0) || (w_sum < r_best_d))) begin
                r_best   <= r_idx2;
                r_best_d <= w_sum;
            end
        end
        // stage 1: index follows the read
        r_idx1 <= r_addr[IDX_W-1:0];
        // stage 2: per-axis squares
        r_idx2 <= r_idx1;
        r_sq_x <= sq_abs_diff(r_px, w_rd_data[COORD_BITS-1:0]);
        r_sq_y <= sq_abs_diff(r_py, w_rd_data[2*COORD_BITS-1:COORD_BITS]);
        r_sq_z <= sq_abs_diff(r_pz, w_rd_data[3*COORD_BITS-1:2*COORD_BITS]);
        // result
        if (i_cmd.finish) begin
            r_node_index <= NODE_W'(n_node);
            r_reused     <= n_reused;
            r_status     <= n_status;
            r_dist       <= sat_dist(r_best_d);
        end
    end

    assign o_sts.scan_done = (r_addr == r_count);
    assign o_sts.pipe_busy = r_v1 | r_v2;
    assign o_sts.out_free  = !r_out_valid | i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_node_index = r_node_index;
    assign o_reused     = r_reused;
    assign o_status     = r_status;
    assign o_dist       = r_dist;

    // Store never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    // Reads stay inside the filled part of the store
    a_read_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (r_addr < r_count))
        else $error("read beyond stored points");

    // A finished transaction always presents a result
    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("result lost after finish");

    // Appends only happen with the pipeline empty
    a_append_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> !r_v1 && !r_v2)
        else $error("append during scan");

endmodule

// File: rtl/point_weld_nearest_lookup.sv
// Point weld store with nearest-point lookup. Each input transaction carries a
// signed Q8.8 point (x, y, z in tdata) and an opcode in tuser: find-or-add,
// add, or locate. The block scans every stored point once, one point per clock
// through the store's single read port, then reuses, appends or reports the
// nearest one and returns one result. After acceptance it reads the stored
// points, sees the end of the scan, waits for the distance pipeline to drain
// and decides, loading the result once the result register is free. The
// controller is back in idle as the result is loaded, so a new transaction is
// not accepted before the previous one has finished; a full store holds 1024
// points. A new transaction is taken once the previous one has produced its
// result, even while that result still waits on the output. The store needs
// no clearing after reset; the tolerance register resets to 0, so nothing is
// welded until it is written.
module point_weld_nearest_lookup
    import pwnl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tolerance register write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [DIST_W-1:0]    i_cfg_data,     // weld_tolerance_sq
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // point_x, point_y, point_z
    input  logic [OP_W-1:0]      s_axis_tuser,   // opcode
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // node_index, nearest_dist_sq, pad
    output logic [M_TUSER_W-1:0] m_axis_tuser    // reused, status
);

    t_ctl_cmd            w_cmd;
    t_ctl_sts            w_sts;
    logic [NODE_W-1:0]   w_node_index;
    logic                w_reused;
    logic [STATUS_W-1:0] w_status;
    logic [DIST_W-1:0]   w_dist;

    assign o_cfg_ready = 1'b1;

    pwnl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pwnl_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (s_axis_tuser),
        .i_px         (s_axis_tdata[COORD_BITS-1:0]),
        .i_py         (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_pz         (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_node_index (w_node_index),
        .o_reused     (w_reused),
        .o_status     (w_status),
        .o_dist       (w_dist)
    );

    // Pack result fields, lowest first
    assign m_axis_tdata = M_TDATA_W'({w_dist, w_node_index});
    assign m_axis_tuser = {w_status, w_reused};

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import pwnl_pkg::*;

    // Opcode three decodes as locate
    localparam logic [OP_W-1:0] OP_LOCATE_ALIAS = 2'd3;

    localparam logic [DIST_W-1:0] DIST_ALL_ONES = {DIST_W{1'b1}};
    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam int COORD_HI = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_LO = -(1 << (COORD_BITS - 1));

    localparam int RANDOM_ITEMS = 564;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int TAIL_CYCLES  = MAX_POINTS + 16;

    // One result as the block reports it
    typedef struct packed {
        logic [NODE_W-1:0]   node_index;
        logic                reused;
        logic [STATUS_W-1:0] status;
        logic [DIST_W-1:0]   dist_sq;
    } weld_answer_t;

    // Mirror of the point store; predicts one answer per accepted point
    class weld_tracker;
        logic signed [COORD_BITS-1:0] kept_x [MAX_POINTS];
        logic signed [COORD_BITS-1:0] kept_y [MAX_POINTS];
        logic signed [COORD_BITS-1:0] kept_z [MAX_POINTS];
        int unsigned       count;
        logic [DIST_W-1:0] tolerance;
        weld_answer_t      answers_due [$];
        int unsigned       answers_seen;
        int unsigned       errors;

        function new();
            count        = 0;
            tolerance    = '0;
            answers_seen = 0;
            errors       = 0;
        endfunction

        function longint unsigned sq_gap(logic signed [COORD_BITS-1:0] a,
                                         logic signed [COORD_BITS-1:0] b);
            longint d;
            d = longint'(a) - longint'(b);
            if (d < 0) d = -d;
            return d * d;
        endfunction

        // Scan, decide and append exactly as the store would
        function void accept_point(logic [OP_W-1:0] op,
                                   logic signed [COORD_BITS-1:0] px,
                                   logic signed [COORD_BITS-1:0] py,
                                   logic signed [COORD_BITS-1:0] pz);
            weld_answer_t    ans;
            longint unsigned d;
            longint unsigned best_d;
            int unsigned     best;
            int unsigned     i;
            bit              grow_store;
            ans        = '0;
            best       = 0;
            best_d     = 0;
            grow_store = 1'b0;
            for (i = 0; i < count; i++) begin
                d = sq_gap(px, kept_x[i]) + sq_gap(py, kept_y[i]) + sq_gap(pz, kept_z[i]);
                // strict compare keeps the lowest index on ties
                if (i == 0 || d < best_d) begin
                    best   = i;
                    best_d = d;
                end
            end
            case (op)
                OP_FIND_OR_ADD: begin
                    if (count > 0 && best_d < tolerance) begin
                        ans.node_index = NODE_W'(best);
                        ans.reused     = 1'b1;
                    end else begin
                        grow_store = 1'b1;
                    end
                end
                OP_ADD: begin
                    grow_store = 1'b1;
                end
                default: begin
                    if (count == 0) begin
                        ans.status = ST_EMPTY;
                    end else begin
                        ans.node_index = NODE_W'(best);
                        ans.reused     = 1'b1;
                    end
                end
            endcase
            if (grow_store) begin
                if (count >= MAX_POINTS) begin
                    ans.node_index = NODE_W'(best);
                    ans.status     = ST_FULL;
                end else begin
                    kept_x[count]  = px;
                    kept_y[count]  = py;
                    kept_z[count]  = pz;
                    ans.node_index = NODE_W'(count);
                    count++;
                end
            end
            ans.dist_sq = (best_d > DIST_ALL_ONES) ? DIST_ALL_ONES : best_d[DIST_W-1:0];
            answers_due = {answers_due, ans};
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] MISMATCH answer %0d: %s", $time, answers_seen, msg);
            errors++;
        endtask

        // Compare one delivered answer with the oldest prediction
        task check_answer(weld_answer_t got);
            weld_answer_t want;
            if (answers_due.size() == 0) begin
                flag_mismatch("answer with no point outstanding");
                answers_seen++;
                return;
            end
            want = answers_due.pop_front();
            if (got.node_index !== want.node_index)
                flag_mismatch($sformatf("node_index got %0d want %0d",
                                        got.node_index, want.node_index));
            if (got.reused !== want.reused)
                flag_mismatch($sformatf("reused got %0b want %0b", got.reused, want.reused));
            if (got.status !== want.status)
                flag_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.dist_sq !== want.dist_sq)
                flag_mismatch($sformatf("nearest_dist_sq got %0d want %0d",
                                        got.dist_sq, want.dist_sq));
            answers_seen++;
        endtask
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [DIST_W-1:0]    i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // point_x, point_y, point_z
    logic [OP_W-1:0]      s_axis_tuser  = '0;   // opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // node_index, nearest_dist_sq, pad
    logic [M_TUSER_W-1:0] m_axis_tuser;         // reused, status

    weld_tracker  tracker;
    int           tx_idle_pct  = 16;
    int           rx_idle_pct  = 16;
    int           rx_hold_left = 0;
    int unsigned  cycle_count  = 0;

    point_weld_nearest_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Transaction monitor: answers first, since an answer never belongs to a
    // point taken on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_answer('{node_index: m_axis_tdata[0 +: NODE_W],
                                       reused:     m_axis_tuser[0],
                                       status:     m_axis_tuser[1 +: STATUS_W],
                                       dist_sq:    m_axis_tdata[NODE_W +: DIST_W]});
            if (s_axis_tvalid && s_axis_tready)
                tracker.accept_point(s_axis_tuser,
                                     s_axis_tdata[0 +: COORD_BITS],
                                     s_axis_tdata[COORD_BITS +: COORD_BITS],
                                     s_axis_tdata[2*COORD_BITS +: COORD_BITS]);
        end
    end

    // Result side: random stalls, or a long hold-off when requested
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic signed [COORD_BITS-1:0] corner_coord();
        case ($urandom_range(3))
            0:       return CMIN;
            1:       return CMAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] nudge(logic signed [COORD_BITS-1:0] c,
                                                           int span);
        int v;
        v = int'(c) + int'($urandom_range(2 * span)) - span;
        if (v > COORD_HI) v = COORD_HI;
        if (v < COORD_LO) v = COORD_LO;
        return COORD_BITS'(v);
    endfunction

    // Nearly half the points near (or on) stored ones, so welds and ties happen
    task automatic random_point(output logic signed [COORD_BITS-1:0] px,
                                output logic signed [COORD_BITS-1:0] py,
                                output logic signed [COORD_BITS-1:0] pz);
        int unsigned pick;
        int unsigned idx;
        int          span;
        pick = $urandom_range(99);
        if (pick < 45 && tracker.count > 0) begin
            idx  = $urandom_range(tracker.count - 1);
            span = (pick < 8) ? 0 : (1 << $urandom_range(7));
            px   = nudge(tracker.kept_x[idx], span);
            py   = nudge(tracker.kept_y[idx], span);
            pz   = nudge(tracker.kept_z[idx], span);
        end else if (pick < 85) begin
            px = COORD_BITS'($urandom);
            py = COORD_BITS'($urandom);
            pz = COORD_BITS'($urandom);
        end else begin
            px = corner_coord();
            py = corner_coord();
            pz = corner_coord();
        end
    endtask

    // Offer one point; returns on the edge that accepts it
    task automatic send_point(input logic [OP_W-1:0] op,
                              input logic signed [COORD_BITS-1:0] px,
                              input logic signed [COORD_BITS-1:0] py,
                              input logic signed [COORD_BITS-1:0] pz);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= S_TDATA_W'({pz, py, px});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random_item();
        logic [OP_W-1:0]              op;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
        int unsigned                  r;
        r  = $urandom_range(99);
        op = (r < 45) ? OP_FIND_OR_ADD :
             (r < 60) ? OP_ADD :
             (r < 94) ? OP_LOCATE : OP_LOCATE_ALIAS;
        random_point(px, py, pz);
        send_point(op, px, py, pz);
    endtask

    // Stop offering and wait until every answer is in
    task automatic settle(input int extra);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.answers_due.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [DIST_W-1:0] value);
        settle(4);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.tolerance = value;
    endtask

    // Main sequence
    initial begin
        int item;
        int ph;
        int k;

        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, reset tolerance of zero
        send_point(OP_LOCATE, '0, '0, '0);
        send_point(OP_LOCATE_ALIAS, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   COORD_BITS'($urandom));
        send_point(OP_FIND_OR_ADD, CMAX, CMAX, CMAX);
        // widest distance the coordinates allow
        send_point(OP_LOCATE, CMIN, CMIN, CMIN);
        send_point(OP_ADD, CMIN, CMIN, CMIN);
        // zero tolerance never welds, even an exact match
        send_point(OP_FIND_OR_ADD, '0, '0, '0);
        send_point(OP_FIND_OR_ADD, '0, '0, '0);
        // exact tie: lower index wins
        send_point(OP_LOCATE, '0, '0, '0);
        send_point(OP_LOCATE_ALIAS, COORD_BITS'(1), COORD_BITS'(-1), COORD_BITS'(1));
        send_point(OP_ADD, CMAX, CMIN, '0);

        // Tolerance of one: distance zero welds, distance one does not
        write_tolerance(DIST_W'(1));
        send_point(OP_FIND_OR_ADD, '0, '0, '0);
        send_point(OP_FIND_OR_ADD, '0, '0, COORD_BITS'(1));

        // Widest tolerance: every find-or-add welds
        write_tolerance(DIST_ALL_ONES);
        send_point(OP_FIND_OR_ADD, CMIN, CMAX, COORD_BITS'($urandom));
        send_point(OP_ADD, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   COORD_BITS'($urandom));
        send_point(OP_LOCATE_ALIAS, CMAX, CMAX, CMIN);

        // Random: four tolerance settings while the store grows
        item = 0;
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       write_tolerance(DIST_W'($urandom_range(20000, 1)));
                1:       write_tolerance(DIST_W'({$urandom_range(3), $urandom}));
                2:       write_tolerance(DIST_ALL_ONES);
                default: write_tolerance('0);
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // long result hold-off so the block backs up into its input
                if (item == 60) rx_hold_left = 400;
                // stretch without any idling on either side
                if (item == 300) begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                if (item == 420) begin
                    tx_idle_pct = 16;
                    rx_idle_pct = 16;
                end
                send_random_item();
                item++;
            end
        end

        settle(TAIL_CYCLES);
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
